>>> design/far_pkg.sv
// shared types and constants for the fraction add-and-reduce block
`timescale 1ns / 1ps

package far_pkg;

	localparam int OPND_BITS = 31;
	localparam int OUT_BITS  = 63;

	typedef struct packed {
		logic [OPND_BITS-1:0] num_a;
		logic [OPND_BITS-1:0] den_a;
		logic [OPND_BITS-1:0] num_b;
		logic [OPND_BITS-1:0] den_b;
	} item_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] sum_num;
		logic [OUT_BITS-1:0] sum_den;
	} result_t;

	// start/done pair between the sequencer and an iterative unit
	typedef struct packed {
		logic start;
	} unit_req_t;

	typedef struct packed {
		logic done;
	} unit_rsp_t;

endpackage

>>> design/far_gcd.sv
// iterative binary gcd unit: one subtract or shift step per cycle
`timescale 1ns / 1ps

module far_gcd import far_pkg::*; #(
	parameter int GW = 63
) (
	input  logic          clk,
	input  logic          arst_n,
	input  unit_req_t     req,
	input  logic [GW-1:0] a,
	input  logic [GW-1:0] b,
	output unit_rsp_t     rsp,
	output logic [GW-1:0] g
);

	localparam int KW = $clog2(GW + 1);

	logic          busy_q, fin_q, done_q;
	logic [GW-1:0] x_q, y_q;
	logic [KW-1:0] k_q;
	logic [GW-1:0] x_minus_y, y_minus_x;
	logic          x_ge_y;
	logic          any_zero;

	assign x_minus_y = x_q - y_q;
	assign y_minus_x = y_q - x_q;
	assign x_ge_y    = (x_q >= y_q);
	assign any_zero  = (x_q == '0) || (y_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
			end else if (busy_q && fin_q && (k_q == '0)) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end else if (busy_q && !fin_q && any_zero) begin
				fin_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= a;
			y_q <= b;
			k_q <= '0;
		end else if (busy_q) begin
			if (fin_q) begin
				// put back the common factors of two
				if (k_q != '0) begin
					x_q <= {x_q[GW-2:0], 1'b0};
					k_q <= k_q - 1'b1;
				end
			end else if (any_zero) begin
				x_q <= x_q | y_q;
			end else if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_ge_y) begin
				// difference of two odd values is even
				x_q <= x_minus_y >> 1;
			end else begin
				y_q <= y_minus_x >> 1;
			end
		end
	end

	assign rsp.done = done_q;
	assign g        = x_q;

endmodule

>>> design/far_div.sv
// restoring divider: one quotient bit per cycle
`timescale 1ns / 1ps

module far_div import far_pkg::*; #(
	parameter int DW = 63
) (
	input  logic          clk,
	input  logic          arst_n,
	input  unit_req_t     req,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output unit_rsp_t     rsp,
	output logic [DW-1:0] quot
);

	localparam int CW = $clog2(DW + 1);

	logic          busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] r_q, q_q, d_q;
	logic [DW:0]   sh, trial;

	assign sh    = {r_q, q_q[DW-1]};
	assign trial = sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q <= '0;
			q_q <= dividend;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DW]) begin
				r_q <= trial[DW-1:0];
				q_q <= {q_q[DW-2:0], 1'b1};
			end else begin
				r_q <= sh[DW-1:0];
				q_q <= {q_q[DW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign quot     = q_q;

endmodule

>>> design/fraction_add_reduce_core.sv
// fraction adder with gcd reduction over shared gcd, divide and multiply units
// one transaction at a time, handled by a gcd run, two divides, three multiplies, an add,
// a second gcd run and two more divides; most of the time goes to the bit-serial divider;
// a new transaction can be taken in the same cycle as the result first shows valid;
// a zero denominator skips the units and gives 0/0 by way of the output state
// asynchronous active-low reset clears the sequencer and the output valid; data is not reset
`timescale 1ns / 1ps

module fraction_add_reduce_core import far_pkg::*; #(
	parameter int OPERAND_BITS = 31
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int W  = OPERAND_BITS;
	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 1;

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_G1   = 12'b0000_0000_0010,
		S_DQ1  = 12'b0000_0000_0100,
		S_DQ2  = 12'b0000_0000_1000,
		S_MUL1 = 12'b0000_0001_0000,
		S_MUL2 = 12'b0000_0010_0000,
		S_MUL3 = 12'b0000_0100_0000,
		S_ADD  = 12'b0000_1000_0000,
		S_G2   = 12'b0001_0000_0000,
		S_DR1  = 12'b0010_0000_0000,
		S_DR2  = 12'b0100_0000_0000,
		S_OUT  = 12'b1000_0000_0000
	} state_t;

	state_t  state_q;
	logic    go_q;
	logic    out_valid_q;
	result_t out_q;

	logic [W-1:0]  na_q, da_q, nb_q, db_q;
	logic [W-1:0]  q1_q, q2_q;
	logic [PW-1:0] prod_q, common_q;
	logic [SW-1:0] total_q;
	logic [SW-1:0] res_num_q, res_den_q;

	logic          zero_den;
	logic          out_free;

	unit_req_t     gcd_req, div_req;
	unit_rsp_t     gcd_rsp, div_rsp;
	logic [SW-1:0] gcd_a, gcd_b, gcd_g;
	logic [SW-1:0] div_n, div_d, div_q;
	logic [W-1:0]  mul_a, mul_b;
	logic [PW-1:0] mul_p;

	assign zero_den = (item.den_a[W-1:0] == '0) || (item.den_b[W-1:0] == '0);
	assign out_free = !out_valid_q || !result_stall;

	assign gcd_req.start = go_q && ((state_q == S_G1) || (state_q == S_G2));
	assign div_req.start = go_q && ((state_q == S_DQ1) || (state_q == S_DQ2) ||
		(state_q == S_DR1) || (state_q == S_DR2));

	always_comb begin
		if (state_q == S_G1) begin
			gcd_a = SW'(da_q);
			gcd_b = SW'(db_q);
		end else begin
			gcd_a = total_q;
			gcd_b = SW'(common_q);
		end
	end

	// common/da = db/g and common/db = da/g
	always_comb begin
		case (state_q)
			S_DQ1: begin
				div_n = SW'(db_q);
				div_d = gcd_g;
			end
			S_DQ2: begin
				div_n = SW'(da_q);
				div_d = gcd_g;
			end
			S_DR1: begin
				div_n = total_q;
				div_d = gcd_g;
			end
			S_DR2: begin
				div_n = SW'(common_q);
				div_d = gcd_g;
			end
			default: begin
				div_n = total_q;
				div_d = gcd_g;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			S_MUL1: begin
				mul_a = da_q;
				mul_b = q1_q;
			end
			S_MUL2: begin
				mul_a = na_q;
				mul_b = q1_q;
			end
			S_MUL3: begin
				mul_a = nb_q;
				mul_b = q2_q;
			end
			default: begin
				mul_a = na_q;
				mul_b = q1_q;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	far_gcd #(.GW(SW)) u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (gcd_req),
		.a      (gcd_a),
		.b      (gcd_b),
		.rsp    (gcd_rsp),
		.g      (gcd_g)
	);

	far_div #(.DW(SW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_n),
		.divisor  (div_d),
		.rsp      (div_rsp),
		.quot     (div_q)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						if (zero_den) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_G1;
							go_q    <= 1'b1;
						end
					end
				end
				S_G1: begin
					if (gcd_rsp.done) begin
						state_q <= S_DQ1;
						go_q    <= 1'b1;
					end
				end
				S_DQ1: begin
					if (div_rsp.done) begin
						state_q <= S_DQ2;
						go_q    <= 1'b1;
					end
				end
				S_DQ2: begin
					if (div_rsp.done) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_MUL3;
				S_MUL3: state_q <= S_ADD;
				S_ADD: begin
					state_q <= S_G2;
					go_q    <= 1'b1;
				end
				S_G2: begin
					if (gcd_rsp.done) begin
						state_q <= S_DR1;
						go_q    <= 1'b1;
					end
				end
				S_DR1: begin
					if (div_rsp.done) begin
						state_q <= S_DR2;
						go_q    <= 1'b1;
					end
				end
				S_DR2: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				na_q      <= item.num_a[W-1:0];
				da_q      <= item.den_a[W-1:0];
				nb_q      <= item.num_b[W-1:0];
				db_q      <= item.den_b[W-1:0];
				res_num_q <= '0;
				res_den_q <= '0;
			end
			S_DQ1: begin
				if (div_rsp.done) begin
					q1_q <= div_q[W-1:0];
				end
			end
			S_DQ2: begin
				if (div_rsp.done) begin
					q2_q <= div_q[W-1:0];
				end
			end
			S_MUL1: prod_q <= mul_p;
			S_MUL2: begin
				common_q <= prod_q;
				prod_q   <= mul_p;
			end
			S_MUL3: begin
				total_q <= SW'(prod_q);
				prod_q  <= mul_p;
			end
			S_ADD: total_q <= total_q + SW'(prod_q);
			S_DR1: begin
				if (div_rsp.done) begin
					res_num_q <= div_q;
				end
			end
			S_DR2: begin
				if (div_rsp.done) begin
					res_den_q <= div_q;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_q.sum_num <= OUT_BITS'(res_num_q);
					out_q.sum_den <= OUT_BITS'(res_den_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

>>> design/far_chk.sv
// port-level checker for the fraction adder, bound to the top level
`timescale 1ns / 1ps

module far_chk import far_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// one transaction in flight: the input closes right after acceptance
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second item taken while busy");

	// a zero denominator only comes with a zero numerator (error code)
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.sum_den == '0) |-> (result.sum_num == '0))
		else $error("zero denominator with non-zero numerator");

	// a zero sum is reported as 0/1 or as the error code 0/0
	a_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.sum_num == '0) |->
			(result.sum_den == OUT_BITS'(1)) || (result.sum_den == '0))
		else $error("zero sum not reduced to 0/1");

endmodule

bind fraction_add_reduce_core far_chk u_far_chk (.*);
